@@ sv/strp_pkg.sv @@
package strp_pkg;

  // Width of a millisecond value
  localparam int unsigned MsW = 29;
  // Length of the dd:dd:dd,ddd pattern and width of a position index
  localparam int unsigned PatLen = 12;
  localparam int unsigned PosW = 4;
  localparam int unsigned CountW = 2;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharComma = 8'h2C;
  // Marks a digit position in the expected-byte table
  localparam logic [7:0] CharDigit = 8'h00;

  localparam logic [PosW-1:0] LastPos = PosW'(PatLen - 1);

  // Matches completed on the current line
  localparam logic [CountW-1:0] CntNone  = 2'd0;
  localparam logic [CountW-1:0] CntStart = 2'd1;
  localparam logic [CountW-1:0] CntRange = 2'd2;

  // Line result handed to the output register
  typedef struct packed {
    logic           start_found;
    logic           range_found;
    logic [MsW-1:0] start_ms;
    logic [MsW-1:0] end_ms;
  } strp_result_t;

  // Expected byte at each pattern position, CharDigit where a digit goes
  function automatic logic [7:0] pat_expect(input logic [PosW-1:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd2, 4'd5: ch = CharColon;
      4'd8:       ch = CharComma;
      default:    ch = CharDigit;
    endcase
    return ch;
  endfunction

  // Millisecond weight of the digit at each pattern position
  function automatic logic [MsW-1:0] pat_weight(input logic [PosW-1:0] pos);
    logic [MsW-1:0] w;
    case (pos)
      4'd0:    w = MsW'(36000000);
      4'd1:    w = MsW'(3600000);
      4'd3:    w = MsW'(600000);
      4'd4:    w = MsW'(60000);
      4'd6:    w = MsW'(10000);
      4'd7:    w = MsW'(1000);
      4'd9:    w = MsW'(100);
      4'd10:   w = MsW'(10);
      4'd11:   w = MsW'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ sv/subtitle_time_range_parser.sv @@
// Subtitle time-range parser.
// Input channel: one byte of a text line per request (char_in_i), with
// end_of_line_i set on the line's last byte; in_valid_i / in_stall_o.
// The line is searched for "dd:dd:dd,ddd" twice; each match is converted to
// milliseconds. A mismatching byte resets the match and is not retried.
// Output channel: one request per line, issued for the end-of-line byte:
// start_found_o, range_found_o, start_ms_o, end_ms_o (zero when not found);
// out_valid_o / out_stall_i.
// Throughput: one byte per cycle unless a line-end byte waits for room in
// the output register. The byte is registered, then matched and accumulated
// (one constant-weight multiply-add) and the line result is registered.
// When the receiver stalls, the result stays in the output register; bytes
// that are not line ends keep flowing, and the next line-end byte waits in
// the input register, which then stalls the sender.
// Reset clears the match state and both valid flags; no results are pending.
module subtitle_time_range_parser
  import strp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     char_in_i,
  input  logic           end_of_line_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           start_found_o,
  output logic           range_found_o,
  output logic [MsW-1:0] start_ms_o,
  output logic [MsW-1:0] end_ms_o
);

  logic         item_valid;
  logic [7:0]   item_char;
  logic         item_eol;
  logic         item_take;
  logic         out_free;
  logic         res_valid;
  strp_result_t res;

  strp_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .end_of_line_i (end_of_line_i),
    .take_i        (item_take),
    .valid_o       (item_valid),
    .char_o        (item_char),
    .eol_o         (item_eol)
  );

  strp_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .char_i       (item_char),
    .eol_i        (item_eol),
    .out_free_i   (out_free),
    .item_take_o  (item_take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  strp_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .start_found_o (start_found_o),
    .range_found_o (range_found_o),
    .start_ms_o    (start_ms_o),
    .end_ms_o      (end_ms_o)
  );

endmodule

@@ sv/strp_in_reg.sv @@
module strp_in_reg
  import strp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_line_i,
  // downstream side
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       eol_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       eol_q;
  logic       load;

  // Register can take a new byte when empty or being drained this cycle
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_in_i;
      eol_q  <= end_of_line_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign eol_o   = eol_q;

endmodule

@@ sv/strp_scan.sv @@
module strp_scan
  import strp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  logic [7:0]   char_i,
  input  logic         eol_i,
  input  logic         out_free_i,
  output logic         item_take_o,
  output logic         res_valid_o,
  output strp_result_t res_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [MsW-1:0]    run_q, run_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [MsW-1:0]    first_q, first_d;

  logic [PosW-1:0]   pos;
  logic [7:0]        expect_ch;
  logic              is_digit;
  logic              ok;
  logic [3:0]        digit;
  logic [MsW-1:0]    prod;
  logic [MsW-1:0]    run_sum;
  logic              done;

  // A line-end byte waits for room in the output register
  assign item_take_o = item_valid_i & (~eol_i | out_free_i);
  assign res_valid_o = item_take_o & eol_i;

  // Pattern compare at the current position
  always_comb begin
    pos       = (pos_q > LastPos) ? '0 : pos_q;
    expect_ch = pat_expect(pos);
    is_digit  = (char_i >= CharZero) && (char_i <= CharNine);
    ok        = (expect_ch == CharDigit) ? is_digit : (char_i == expect_ch);
    digit     = (expect_ch == CharDigit && is_digit) ? 4'(char_i - CharZero) : 4'd0;
    prod      = MsW'(digit) * pat_weight(pos);
    run_sum   = run_q + prod;
    done      = (pos == LastPos);
  end

  // Next state after this byte
  always_comb begin
    pos_d   = pos_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    if (cnt_q < CntRange) begin
      if (!ok) begin
        pos_d = '0;
        run_d = '0;
      end else if (done) begin
        pos_d = '0;
        if (cnt_q == CntNone) begin
          first_d = run_sum;
          run_d   = '0;
          cnt_d   = CntStart;
        end else begin
          run_d = run_sum;
          cnt_d = CntRange;
        end
      end else begin
        pos_d = pos + 1'b1;
        run_d = run_sum;
      end
    end
  end

  // Line result from the state after the last byte
  always_comb begin
    res_o.start_found = (cnt_d >= CntStart);
    res_o.range_found = (cnt_d >= CntRange);
    res_o.start_ms    = res_o.start_found ? first_d : '0;
    res_o.end_ms      = res_o.range_found ? run_d : '0;
  end

  // State update; line end clears everything
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      run_q   <= '0;
      cnt_q   <= CntNone;
      first_q <= '0;
    end else if (item_take_o) begin
      if (eol_i) begin
        pos_q   <= '0;
        run_q   <= '0;
        cnt_q   <= CntNone;
        first_q <= '0;
      end else begin
        pos_q   <= pos_d;
        run_q   <= run_d;
        cnt_q   <= cnt_d;
        first_q <= first_d;
      end
    end
  end

endmodule

@@ sv/strp_out_reg.sv @@
module strp_out_reg
  import strp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  strp_result_t   res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           start_found_o,
  output logic           range_found_o,
  output logic [MsW-1:0] start_ms_o,
  output logic [MsW-1:0] end_ms_o
);

  logic         valid_q, valid_d;
  strp_result_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = res_valid_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign start_found_o = res_q.start_found;
  assign range_found_o = res_q.range_found;
  assign start_ms_o    = res_q.start_ms;
  assign end_ms_o      = res_q.end_ms;

endmodule

@@ tb/tb_top.sv @@
module tb_top
  import strp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  logic [7:0]     char_in_i;
  logic           end_of_line_i;
  logic           out_valid_o;
  logic           out_stall_i;
  logic           start_found_o;
  logic           range_found_o;
  logic [MsW-1:0] start_ms_o;
  logic [MsW-1:0] end_ms_o;

  subtitle_time_range_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .start_found_o (start_found_o),
    .range_found_o (range_found_o),
    .start_ms_o    (start_ms_o),
    .end_ms_o      (end_ms_o)
  );

  // Line results still owed by the block, oldest first
  strp_result_t line_results[$];

  // Timestamp scanner mirror
  logic [PosW-1:0]   scan_pos;
  logic [MsW-1:0]    accum_ms;
  logic [CountW-1:0] stamps_done;
  logic [MsW-1:0]    start_stamp;

  int   faults;
  int   worked;
  bit   calm;
  bit   hold_req;
  int   hold_left;

  // Bytes of the line being built
  logic [7:0] line_buf[$];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Byte expected at each pattern slot; CharDigit where any digit fits
  function automatic logic [7:0] glyph_at(input logic [PosW-1:0] p);
    if (p == 4'd2 || p == 4'd5) return CharColon;
    if (p == 4'd8) return CharComma;
    return CharDigit;
  endfunction

  // Millisecond value of one unit in each digit slot
  function automatic logic [MsW-1:0] weight_at(input logic [PosW-1:0] p);
    logic [MsW-1:0] w;
    case (p)
      4'd0:    w = MsW'(36000000);
      4'd1:    w = MsW'(3600000);
      4'd3:    w = MsW'(600000);
      4'd4:    w = MsW'(60000);
      4'd6:    w = MsW'(10000);
      4'd7:    w = MsW'(1000);
      4'd9:    w = MsW'(100);
      4'd10:   w = MsW'(10);
      4'd11:   w = MsW'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

  // Append one byte to the line being built
  task automatic add_byte(input logic [7:0] b);
    line_buf = {line_buf, b};
  endtask

  // Advance the scanner by one accepted byte; queue the line result at line end
  task automatic absorb_byte(input logic [7:0] ch, input logic last);
    logic           hit;
    logic [MsW-1:0] dval;
    strp_result_t   r;
    if (stamps_done != CntRange) begin
      dval = '0;
      if (glyph_at(scan_pos) == CharDigit) begin
        hit = (ch >= CharZero) && (ch <= CharNine);
        dval = MsW'(ch) - MsW'(CharZero);
      end else begin
        hit = (ch == glyph_at(scan_pos));
      end
      if (!hit) begin
        // mismatching byte is dropped, not retried as a new start
        scan_pos = '0;
        accum_ms = '0;
      end else begin
        accum_ms = accum_ms + dval * weight_at(scan_pos);
        if (scan_pos == LastPos) begin
          scan_pos = '0;
          if (stamps_done == CntNone) begin
            start_stamp = accum_ms;
            accum_ms = '0;
            stamps_done = CntStart;
          end else begin
            stamps_done = CntRange;
          end
        end else begin
          scan_pos = scan_pos + 1'b1;
        end
      end
    end
    if (last) begin
      r.start_found = (stamps_done != CntNone);
      r.range_found = (stamps_done == CntRange);
      r.start_ms    = r.start_found ? start_stamp : '0;
      r.end_ms      = r.range_found ? accum_ms : '0;
      line_results = {line_results, r};
      scan_pos    = '0;
      accum_ms    = '0;
      stamps_done = CntNone;
      start_stamp = '0;
    end
  endtask

  // Offer one byte request, with a random gap first, and wait for acceptance
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 17) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_in_i     <= ch;
    end_of_line_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    worked++;
    absorb_byte(ch, last);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic push_noise(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 50) add_byte(8'($urandom_range(255)));
      else if (sel < 70) add_byte(CharZero + 8'($urandom_range(9)));
      else if (sel < 85) add_byte(CharColon);
      else add_byte(CharComma);
    end
  endtask

  // One timestamp, sometimes all nines or all zeros, sometimes with one bad byte
  task automatic push_stamp(input bit corrupt);
    int         mode;
    int         bad;
    logic [7:0] g;
    mode = $urandom_range(9);
    bad = corrupt ? $urandom_range(11) : -1;
    for (int p = 0; p < PatLen; p++) begin
      g = glyph_at(PosW'(p));
      if (g == CharDigit) begin
        if (mode == 0) g = CharNine;
        else if (mode == 1) g = CharZero;
        else g = CharZero + 8'($urandom_range(9));
      end
      if (p == bad) g = 8'($urandom_range(255));
      add_byte(g);
    end
  endtask

  // Mostly "<noise>stamp<sep>stamp<noise>", some broken, some cut short
  task automatic build_line();
    int shape;
    int keep;
    shape = $urandom_range(99);
    push_noise($urandom_range(0, 3));
    if (shape < 80) begin
      push_stamp($urandom_range(99) < 15);
      if ($urandom_range(1)) begin
        add_byte(8'h20);
        add_byte(8'h2D);
        add_byte(8'h2D);
        add_byte(8'h3E);
        add_byte(8'h20);
      end else begin
        push_noise($urandom_range(0, 2));
      end
      push_stamp($urandom_range(99) < 15);
      push_noise($urandom_range(0, 4));
    end else if (shape < 90) begin
      push_stamp($urandom_range(99) < 30);
      push_noise($urandom_range(0, 4));
    end else begin
      push_noise($urandom_range(1, 30));
    end
    if (line_buf.size() == 0) push_noise(1);
    // cut some lines short so a match is left open at the end
    if ($urandom_range(99) < 10) begin
      keep = $urandom_range(1, line_buf.size());
      while (line_buf.size() > keep) void'(line_buf.pop_back());
    end
  endtask

  // Hold the sender until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (line_results.size() != 0);
  endtask

  // Extremes, back-to-back stamps, ignored tail, non-ASCII, partial at line end
  task automatic test_directed();
    string s;
    s = "99:99:99,99900:00:00,000";
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    add_byte(8'hFF);
    send_line();
    s = "12:3";
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_line();
    add_byte(8'h80);
    send_line();
  endtask

  task automatic test_random_lines();
    int n;
    n = 0;
    worked = 0;
    while (worked < 950) begin
      calm = (n >= 15 && n < 35);
      build_line();
      send_line();
      n++;
    end
    calm = 1'b0;
  endtask

  // Receiver holds off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    calm = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) push_noise($urandom_range(1, 3));
      else build_line();
      send_line();
    end
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    drain_results();
    for (int i = 0; i < 4; i++) begin
      build_line();
      send_line();
    end
  endtask

  // Result receiver: random stalls plus requested long hold-offs
  initial begin
    out_stall_i <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 17);
      end
    end
  end

  // Compare each accepted line result with the oldest owed one
  initial begin
    strp_result_t got;
    strp_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.start_found = start_found_o;
        got.range_found = range_found_o;
        got.start_ms    = start_ms_o;
        got.end_ms      = end_ms_o;
        if (line_results.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected line result: sf=%0b rf=%0b start=%0d end=%0d",
                     got.start_found, got.range_found, got.start_ms, got.end_ms);
        end else begin
          want = line_results.pop_front();
          if (got.start_found !== want.start_found ||
              got.range_found !== want.range_found ||
              got.start_ms !== want.start_ms || got.end_ms !== want.end_ms) begin
            faults++;
            if (faults <= 10)
              $display("mismatch: exp sf=%0b rf=%0b %0d-%0d got sf=%0b rf=%0b %0d-%0d",
                       want.start_found, want.range_found, want.start_ms, want.end_ms,
                       got.start_found, got.range_found, got.start_ms, got.end_ms);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    int wait_cnt;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    char_in_i     <= '0;
    end_of_line_i <= 1'b0;
    faults = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    scan_pos = '0;
    accum_ms = '0;
    stamps_done = CntNone;
    start_stamp = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_lines();
    test_backpressure();
    test_drain_pause();

    in_valid_i <= 1'b0;
    wait_cnt = 0;
    while (line_results.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(posedge clk_i);
    if (faults == 0 && line_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
